>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros included by the framer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Property checked at every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> sv/dfusf_pkg.sv
// ----------------------------------------------------------------------------
// dfusf_pkg
// Constants, register indexes and CRC helper for the DFU suffix framer.
// ----------------------------------------------------------------------------
package dfusf_pkg;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] LEN_ADD  = 32'd16;

    localparam int          CFG_W    = 32;
    localparam int          IDX_W    = 3;

    localparam logic [3:0]  SFX_CRC_FIRST = 4'd12;
    localparam logic [3:0]  SFX_FINAL     = 4'd15;

    typedef enum logic [IDX_W-1:0] {
        REG_IMAGE_LENGTH   = 3'd0,
        REG_LENGTH_OFFSET  = 3'd1,
        REG_DEVICE_RELEASE = 3'd2,
        REG_PRODUCT_ID     = 3'd3,
        REG_VENDOR_ID      = 3'd4,
        REG_DFU_VERSION    = 3'd5,
        REG_SIGNATURE      = 3'd6,
        REG_SUFFIX_LENGTH  = 3'd7
    } t_cfg_reg;

    // Reflected CRC-32, one byte.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> sv/dfu_image_suffix_framer.sv
// ----------------------------------------------------------------------------
// dfu_image_suffix_framer
// Patches the frame length into the image and appends a DFU suffix and CRC-32.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one image byte per request.
// Output channel: o_out_valid / i_out_stall carry one framed byte per request,
// o_last marks the final CRC byte of a frame.
// Config: write i_cfg_data to register i_cfg_index when i_cfg_we is high;
// write only while no frame is in flight.
// An accepted byte is loaded into the output register at the edge that accepts it.
// Throughput: one image byte per cycle while the receiver takes bytes. After
// the last image byte, 12 suffix bytes and 4 CRC bytes come from a 16-step
// sequencer, one per cycle unless the receiver stalls, with the input stalled.
// The single output register loads whenever it is empty or being taken, so
// a receiver stall holds the output byte and stalls the input in the same cycle.
// Reset clears the frame position, the CRC, the sequencer and the output valid,
// and loads the register defaults; no clearing pass is needed.
module dfu_image_suffix_framer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [7:0]                         i_data_byte,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [7:0]                         o_out_byte,
    output logic                               o_last,
    input  logic                               i_cfg_we,
    input  logic [dfusf_pkg::IDX_W-1:0]        i_cfg_index,
    input  logic [dfusf_pkg::CFG_W-1:0]        i_cfg_data
);

    logic [31:0] r_image_length;
    logic [15:0] r_length_offset;
    logic [15:0] r_device_release;
    logic [15:0] r_product_id;
    logic [15:0] r_vendor_id;
    logic [15:0] r_dfu_version;
    logic [23:0] r_signature;
    logic [7:0]  r_suffix_length;

    logic [31:0] r_pos,  n_pos;
    logic [31:0] r_crc,  n_crc;
    logic        r_sfx_active, n_sfx_active;
    logic [3:0]  r_sfx_idx,    n_sfx_idx;
    logic        r_out_valid,  n_out_valid;
    logic [7:0]  r_out_byte,   n_out_byte;
    logic        r_out_last,   n_out_last;

    logic        w_out_free;
    logic        w_in_acc;
    logic        w_sfx_step;
    logic [32:0] w_rel;
    logic        w_hit;
    logic [31:0] w_total;
    logic [31:0] w_len_eff;
    logic        w_img_last;
    logic [7:0]  w_img_byte;
    logic [7:0]  w_sfx_byte;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_length   <= 32'd1;
            r_length_offset  <= 16'd32;
            r_device_release <= 16'h0100;
            r_product_id     <= 16'h0140;
            r_vendor_id      <= 16'h0419;
            r_dfu_version    <= 16'h0100;
            r_signature      <= 24'h554644;
            r_suffix_length  <= 8'd16;
        end else if (i_cfg_we) begin
            unique case (dfusf_pkg::t_cfg_reg'(i_cfg_index))
                dfusf_pkg::REG_IMAGE_LENGTH:   r_image_length   <= i_cfg_data[31:0];
                dfusf_pkg::REG_LENGTH_OFFSET:  r_length_offset  <= i_cfg_data[15:0];
                dfusf_pkg::REG_DEVICE_RELEASE: r_device_release <= i_cfg_data[15:0];
                dfusf_pkg::REG_PRODUCT_ID:     r_product_id     <= i_cfg_data[15:0];
                dfusf_pkg::REG_VENDOR_ID:      r_vendor_id      <= i_cfg_data[15:0];
                dfusf_pkg::REG_DFU_VERSION:    r_dfu_version    <= i_cfg_data[15:0];
                dfusf_pkg::REG_SIGNATURE:      r_signature      <= i_cfg_data[23:0];
                dfusf_pkg::REG_SUFFIX_LENGTH:  r_suffix_length  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_sfx_active || !w_out_free;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_sfx_step = r_sfx_active && w_out_free;

    // length field patch
    assign w_total   = r_image_length + dfusf_pkg::LEN_ADD;
    assign w_rel     = {1'b0, r_pos} - ({17'd0, r_length_offset} + 33'd4);
    assign w_hit     = !w_rel[32] && (w_rel[31:2] == 30'd0);
    assign w_len_eff = (r_image_length == 32'd0) ? 32'd1 : r_image_length;
    assign w_img_last = ({1'b0, r_pos} + 33'd1) >= {1'b0, w_len_eff};

    always_comb begin
        w_img_byte = i_data_byte;
        if (w_hit) begin
            case (w_rel[1:0])
                2'd0:    w_img_byte = w_total[7:0];
                2'd1:    w_img_byte = w_total[15:8];
                2'd2:    w_img_byte = w_total[23:16];
                default: w_img_byte = w_total[31:24];
            endcase
        end
    end

    // suffix byte select
    always_comb begin
        unique case (r_sfx_idx)
            4'd0:    w_sfx_byte = r_device_release[7:0];
            4'd1:    w_sfx_byte = r_device_release[15:8];
            4'd2:    w_sfx_byte = r_product_id[7:0];
            4'd3:    w_sfx_byte = r_product_id[15:8];
            4'd4:    w_sfx_byte = r_vendor_id[7:0];
            4'd5:    w_sfx_byte = r_vendor_id[15:8];
            4'd6:    w_sfx_byte = r_dfu_version[7:0];
            4'd7:    w_sfx_byte = r_dfu_version[15:8];
            4'd8:    w_sfx_byte = r_signature[23:16];
            4'd9:    w_sfx_byte = r_signature[15:8];
            4'd10:   w_sfx_byte = r_signature[7:0];
            4'd11:   w_sfx_byte = r_suffix_length;
            4'd12:   w_sfx_byte = r_crc[7:0];
            4'd13:   w_sfx_byte = r_crc[15:8];
            4'd14:   w_sfx_byte = r_crc[23:16];
            default: w_sfx_byte = r_crc[31:24];
        endcase
    end

    always_comb begin
        n_pos        = r_pos;
        n_crc        = r_crc;
        n_sfx_active = r_sfx_active;
        n_sfx_idx    = r_sfx_idx;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_byte   = r_out_byte;
        n_out_last   = r_out_last;
        if (w_in_acc) begin
            n_out_valid = 1'b1;
            n_out_byte  = w_img_byte;
            n_out_last  = 1'b0;
            n_crc       = dfusf_pkg::crc_byte(r_crc, w_img_byte);
            if (w_img_last) begin
                n_pos        = 32'd0;
                n_sfx_active = 1'b1;
                n_sfx_idx    = 4'd0;
            end else begin
                n_pos = r_pos + 32'd1;
            end
        end else if (w_sfx_step) begin
            n_out_valid = 1'b1;
            n_out_byte  = w_sfx_byte;
            n_out_last  = (r_sfx_idx == dfusf_pkg::SFX_FINAL);
            n_sfx_idx   = r_sfx_idx + 4'd1;
            if (r_sfx_idx < dfusf_pkg::SFX_CRC_FIRST) begin
                n_crc = dfusf_pkg::crc_byte(r_crc, w_sfx_byte);
            end else if (r_sfx_idx == dfusf_pkg::SFX_FINAL) begin
                n_crc        = dfusf_pkg::CRC_INIT;
                n_sfx_active = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= 32'd0;
            r_crc        <= dfusf_pkg::CRC_INIT;
            r_sfx_active <= 1'b0;
            r_sfx_idx    <= 4'd0;
            r_out_valid  <= 1'b0;
        end else begin
            r_pos        <= n_pos;
            r_crc        <= n_crc;
            r_sfx_active <= n_sfx_active;
            r_sfx_idx    <= n_sfx_idx;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last      = r_out_last;

`include "assert_macros.svh"

    `ASSERT_CLK(a_no_in_during_sfx, i_clk, i_rst_n, r_sfx_active |-> o_in_stall, "input taken during suffix")
    `ASSERT_CLK(a_last_starts_sfx, i_clk, i_rst_n, (w_in_acc && w_img_last) |=> (r_sfx_active && r_sfx_idx == 4'd0 && r_pos == 32'd0), "suffix not started")
    `ASSERT_CLK(a_last_clears_crc, i_clk, i_rst_n, (o_out_valid && o_last) |-> (!r_sfx_active && r_crc == dfusf_pkg::CRC_INIT), "frame not closed on last")

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for dfu_image_suffix_framer. Image bytes are sent with
// random gaps and output stalls; a scoreboard tracks frame position, the
// register settings and the running CRC-32, and checks every framed byte and
// its last flag in order. Directed frames cover the length patch, register
// extremes and mid-frame length changes; random phases cover the rest.
// ----------------------------------------------------------------------------
module testbench;

    localparam int N_RANDOM = 260;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic [7:0]                  i_data_byte = 8'd0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic [7:0]                  o_out_byte;
    logic                        o_last;
    logic                        i_cfg_we = 1'b0;
    logic [dfusf_pkg::IDX_W-1:0] i_cfg_index = '0;
    logic [dfusf_pkg::CFG_W-1:0] i_cfg_data = '0;

    bit calm = 1'b0;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_framed_byte;

    class frame_scoreboard;
        logic [31:0]  img_len, len_off, dev_rel, prod_id, vend_id, dfu_ver, sig, sfx_len;
        logic [31:0]  pos, crc;
        t_framed_byte pending[$];
        int           errors, frames, checked, requests;

        function new();
            img_len = 32'd1;
            len_off = 32'd32;
            dev_rel = 32'h0100;
            prod_id = 32'h0140;
            vend_id = 32'h0419;
            dfu_ver = 32'h0100;
            sig     = 32'h554644;
            sfx_len = 32'd16;
            pos     = '0;
            crc     = dfusf_pkg::CRC_INIT;
        endfunction

        function void write_reg(dfusf_pkg::t_cfg_reg idx, logic [31:0] v);
            case (idx)
                dfusf_pkg::REG_IMAGE_LENGTH:   img_len = v;
                dfusf_pkg::REG_LENGTH_OFFSET:  len_off = v & 32'hFFFF;
                dfusf_pkg::REG_DEVICE_RELEASE: dev_rel = v & 32'hFFFF;
                dfusf_pkg::REG_PRODUCT_ID:     prod_id = v & 32'hFFFF;
                dfusf_pkg::REG_VENDOR_ID:      vend_id = v & 32'hFFFF;
                dfusf_pkg::REG_DFU_VERSION:    dfu_ver = v & 32'hFFFF;
                dfusf_pkg::REG_SIGNATURE:      sig     = v & 32'hFF_FFFF;
                dfusf_pkg::REG_SUFFIX_LENGTH:  sfx_len = v & 32'hFF;
                default: ;
            endcase
        endfunction

        function logic [31:0] eff_len();
            return (img_len == 0) ? 32'd1 : img_len;
        endfunction

        // bit-serial form of the reflected CRC-32
        function void add_crc(logic [7:0] d);
            logic fb;
            for (int i = 0; i < 8; i++) begin
                fb  = crc[0] ^ d[i];
                crc = (crc >> 1) ^ (fb ? dfusf_pkg::CRC_POLY : 32'd0);
            end
        endfunction

        function void push(logic [7:0] d, logic lst, bit covered);
            t_framed_byte e;
            e.data = d;
            e.last = lst;
            pending.push_back(e);
            if (covered)
                add_crc(d);
        endfunction

        function void note_request(logic [7:0] din);
            logic [31:0] total;
            logic [32:0] start, p;
            logic [31:0] frame_crc;
            logic [7:0]  d;
            total = img_len + dfusf_pkg::LEN_ADD;
            start = {17'd0, len_off[15:0]} + 33'd4;
            p     = {1'b0, pos};
            d     = din;
            requests++;
            if (p >= start && p < start + 33'd4)
                d = 8'(total >> (8 * (p - start)));
            push(d, 1'b0, 1'b1);
            if (p + 33'd1 >= {1'b0, eff_len()}) begin
                push(dev_rel[7:0], 1'b0, 1'b1);
                push(dev_rel[15:8], 1'b0, 1'b1);
                push(prod_id[7:0], 1'b0, 1'b1);
                push(prod_id[15:8], 1'b0, 1'b1);
                push(vend_id[7:0], 1'b0, 1'b1);
                push(vend_id[15:8], 1'b0, 1'b1);
                push(dfu_ver[7:0], 1'b0, 1'b1);
                push(dfu_ver[15:8], 1'b0, 1'b1);
                push(sig[23:16], 1'b0, 1'b1);
                push(sig[15:8], 1'b0, 1'b1);
                push(sig[7:0], 1'b0, 1'b1);
                push(sfx_len[7:0], 1'b0, 1'b1);
                frame_crc = crc;
                push(frame_crc[7:0], 1'b0, 1'b0);
                push(frame_crc[15:8], 1'b0, 1'b0);
                push(frame_crc[23:16], 1'b0, 1'b0);
                push(frame_crc[31:24], 1'b1, 1'b0);
                pos = '0;
                crc = dfusf_pkg::CRC_INIT;
                frames++;
            end else begin
                pos = pos + 32'd1;
            end
        endfunction

        function void check_result(logic [7:0] d, logic lst);
            t_framed_byte e;
            if (pending.size() == 0) begin
                $error("unexpected output byte %02h last %0b", d, lst);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (d !== e.data) begin
                $error("out_byte mismatch: expected %02h, actual %02h", e.data, d);
                errors++;
            end
            if (lst !== e.last) begin
                $error("last mismatch: expected %0b, actual %0b", e.last, lst);
                errors++;
            end
        endfunction
    endclass

    frame_scoreboard sb = new();

    dfu_image_suffix_framer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_data_byte (i_data_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < 22);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_out_byte, o_last);
    end

    initial begin
        #2_000_000;
        $display("dfu_image_suffix_framer verification failed");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_byte(logic [7:0] b);
        while (!calm && ($urandom_range(99) < 22)) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        do
            @(posedge i_clk);
        while (o_in_stall);
        sb.note_request(b);
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_cfg(dfusf_pkg::t_cfg_reg idx, logic [31:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
        sb.write_reg(idx, v);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_suffix(logic [15:0] dev, logic [15:0] prod, logic [15:0] ven,
                              logic [15:0] ver, logic [23:0] sg, logic [7:0] sl);
        write_cfg(dfusf_pkg::REG_DEVICE_RELEASE, {16'd0, dev});
        write_cfg(dfusf_pkg::REG_PRODUCT_ID, {16'd0, prod});
        write_cfg(dfusf_pkg::REG_VENDOR_ID, {16'd0, ven});
        write_cfg(dfusf_pkg::REG_DFU_VERSION, {16'd0, ver});
        write_cfg(dfusf_pkg::REG_SIGNATURE, {8'd0, sg});
        write_cfg(dfusf_pkg::REG_SUFFIX_LENGTH, {24'd0, sl});
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(4))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    initial begin
        int          sent, nbytes, half, phase;
        logic [31:0] len, eff;
        logic [7:0]  burst[8];

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset defaults: one byte per frame
        send_byte(8'h00);
        send_byte(8'hFF);
        wait_drain();

        // zero length acts as one, suffix all zeros
        set_suffix(16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'h000000, 8'h00);
        write_cfg(dfusf_pkg::REG_IMAGE_LENGTH, 32'd0);
        write_cfg(dfusf_pkg::REG_LENGTH_OFFSET, 32'd0);
        send_byte(8'hA5);
        wait_drain();

        // length patched over bytes 4..7, suffix all ones, pause mid-frame
        set_suffix(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 8'hFF);
        write_cfg(dfusf_pkg::REG_IMAGE_LENGTH, 32'd8);
        burst = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h12, 8'h34, 8'h56, 8'h78};
        for (int i = 0; i < 8; i++) begin
            if (i == 4)
                wait_drain();
            send_byte(burst[i]);
        end
        wait_drain();

        // largest length, then shortened mid-frame so the next byte closes it
        write_cfg(dfusf_pkg::REG_IMAGE_LENGTH, 32'hFFFF_FFEF);
        for (int i = 0; i < 8; i++)
            send_byte(8'h80 >> i);
        wait_drain();
        write_cfg(dfusf_pkg::REG_IMAGE_LENGTH, 32'd3);
        send_byte(8'h01);
        wait_drain();

        // length field beyond the image
        write_cfg(dfusf_pkg::REG_LENGTH_OFFSET, 32'hFFFF);
        write_cfg(dfusf_pkg::REG_IMAGE_LENGTH, 32'd2);
        send_byte(8'h7F);
        send_byte(8'hFE);
        wait_drain();

        sent  = 0;
        phase = 0;
        while (sent < N_RANDOM) begin
            calm = (sent >= 100 && sent < 160);
            case ($urandom_range(9))
                0: len = 32'd0;
                1: len = 32'hFFFF_FFF0 + $urandom_range(15);
                default: len = $urandom_range(1, 40);
            endcase
            write_cfg(dfusf_pkg::REG_IMAGE_LENGTH, len);
            if ($urandom_range(9) < 7)
                write_cfg(dfusf_pkg::REG_LENGTH_OFFSET, $urandom_range(40));
            else
                write_cfg(dfusf_pkg::REG_LENGTH_OFFSET, $urandom_range(16'hFFFF));
            set_suffix(pick16(), pick16(), pick16(), pick16(),
                       {pick16(), 8'(pick16())}, 8'(pick16()));
            eff = sb.eff_len();
            if (len >= 32'hFFFF_FFF0)
                nbytes = $urandom_range(1, 20);
            else if (sb.pos + 32'd1 >= eff)
                nbytes = 1 + ($urandom_range(0, 2) * eff);
            else
                nbytes = (eff - sb.pos) + ($urandom_range(0, 2) * eff);
            if (nbytes > N_RANDOM - sent)
                nbytes = N_RANDOM - sent;
            half = ($urandom_range(7) == 0) ? nbytes / 2 : -1;
            for (int i = 0; i < nbytes; i++) begin
                if (i == half)
                    wait_drain();
                send_byte($urandom_range(255));
            end
            sent += nbytes;
            phase++;
            wait_drain();
        end
        calm = 1'b0;

        wait_drain();
        repeat (20) @(negedge i_clk);
        $display("%0d image bytes in %0d register phases, %0d frames closed, %0d bytes checked",
                 sb.requests, phase, sb.frames, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("dfu_image_suffix_framer verification clean");
        else
            $display("dfu_image_suffix_framer verification failed");
        $finish;
    end

endmodule
